>>> rtl/kcf_pkg.sv
// Package for the keyed circular FIFO.
// Holds default sizes, command and status codes, and the cell control type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kcf_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int DEPTH_DEF     = 16;
  localparam int KEY_BITS_DEF  = 16;
  localparam int DATA_BITS_DEF = 32;

  localparam int MODE_BITS   = 3;
  localparam int STATUS_BITS = 3;

  // Command codes carried in the mode field.
  localparam logic [MODE_BITS-1:0] MODE_ENQ    = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_DEQ    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_PEEK   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_CHANGE = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_MISSING = 3'd4;

  // Control for one storage cell of the ring.
  typedef struct packed {
    logic rotate;  // take key and data from the next cell
    logic load;    // take the new entry from the request
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/kcf_if.sv
// Request and result channel interfaces for the keyed circular FIFO.
// Depends on kcf_pkg for the default sizes and the mode and status widths.
`timescale 1ns / 1ps
`default_nettype none

interface kcf_cmd_if #(
  parameter int KEY_BITS  = kcf_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = kcf_pkg::DATA_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic        [kcf_pkg::MODE_BITS-1:0] mode;
  logic        [KEY_BITS-1:0]           key;
  logic signed [DATA_BITS-1:0]          data;

  modport source (output valid, mode, key, data, input ready);
  modport sink   (input valid, mode, key, data, output ready);
endinterface

interface kcf_rsp_if #(
  parameter int KEY_BITS  = kcf_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = kcf_pkg::DATA_BITS_DEF,
  parameter int CNT_BITS  = $clog2(kcf_pkg::DEPTH_DEF + 1)
);
  logic                                   valid;
  logic                                   ready;
  logic        [kcf_pkg::STATUS_BITS-1:0] status;
  logic        [KEY_BITS-1:0]             out_key;
  logic signed [DATA_BITS-1:0]            out_data;
  logic        [CNT_BITS-1:0]             occupancy;
  logic                                   queue_empty;
  logic        [KEY_BITS-1:0]             front_key;
  logic        [KEY_BITS-1:0]             rear_key;

  modport source (output valid, status, out_key, out_data, occupancy, queue_empty,
                  front_key, rear_key, input ready);
  modport sink   (input valid, status, out_key, out_data, occupancy, queue_empty,
                  front_key, rear_key, output ready);
endinterface

`default_nettype wire

>>> rtl/kcf_cell.sv
// One storage cell of the entry ring: a key and its data.
// Depends on kcf_pkg for the default sizes and the cell control type.
`timescale 1ns / 1ps
`default_nettype none

module kcf_cell #(
  parameter int KEY_BITS  = kcf_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = kcf_pkg::DATA_BITS_DEF
) (
  input  wire                          clk,
  input  kcf_pkg::cell_ctrl_t          ctrl,
  input  wire [KEY_BITS-1:0]           nbr_key,
  input  wire signed [DATA_BITS-1:0]   nbr_data,
  input  wire [KEY_BITS-1:0]           new_key,
  input  wire signed [DATA_BITS-1:0]   new_data,
  output logic [KEY_BITS-1:0]          key,
  output logic signed [DATA_BITS-1:0]  data
);
  import kcf_pkg::*;

  // Rotation wins over loading; the controller never asks for both.
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      key  <= nbr_key;
      data <= nbr_data;
    end else if (ctrl.load) begin
      key  <= new_key;
      data <= new_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/keyed_circular_fifo.sv
// Top level of the keyed circular FIFO: a ring of entry cells and its controller.
// Depends on kcf_pkg, kcf_if (kcf_cmd_if, kcf_rsp_if) and kcf_cell.
//
//   Port   Direction  Carries
//   cmd    in         mode, key, data per request
//   rsp    out        status, out_key, out_data, occupancy, queue_empty,
//                     front_key, rear_key per request
//
// Enqueue, peek and change search the ring by rotating it once past cell 0,
// then pass through the apply and report states into the output register.
// Dequeue, clear and unused modes skip the scan and go straight to apply.
// One request is in work at a time; the next is accepted once the previous
// result sits in the output register, even while that result is stalled.
// Reset (rst, synchronous) empties the queue; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyed_circular_fifo #(
  parameter int DEPTH     = kcf_pkg::DEPTH_DEF,
  parameter int KEY_BITS  = kcf_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = kcf_pkg::DATA_BITS_DEF
) (
  input wire    clk,
  input wire    rst,
  kcf_cmd_if.sink   cmd,
  kcf_rsp_if.source rsp
);
  import kcf_pkg::*;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int STEP_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_REPORT
  } state_t;

  state_t                       state;
  logic [MODE_BITS-1:0]         mode_r;
  logic [KEY_BITS-1:0]          key_r;
  logic signed [DATA_BITS-1:0]  data_r;
  logic [STEP_W-1:0]            step;
  logic [CNT_W-1:0]             count;
  logic [KEY_BITS-1:0]          rear_r;
  logic                         found;
  logic [STATUS_BITS-1:0]       status_r;
  logic [KEY_BITS-1:0]          rkey_r;
  logic signed [DATA_BITS-1:0]  rdata_r;

  logic [KEY_BITS-1:0]          cell_key  [DEPTH];
  logic signed [DATA_BITS-1:0]  cell_data [DEPTH];

  logic                         match_now;
  logic                         rotate;
  logic                         append;
  logic                         edit;
  logic signed [DATA_BITS-1:0]  wrap_data;
  logic                         out_free;

  // Cell 0 holds the oldest entry; during a scan it holds entry number step.
  assign match_now = (state == S_SCAN) && !found &&
                     ({{(CNT_W - STEP_W){1'b0}}, step} < count) &&
                     (cell_key[0] == key_r);

  assign edit   = match_now && (mode_r == MODE_CHANGE);
  assign rotate = (state == S_SCAN) ||
                  ((state == S_APPLY) && (mode_r == MODE_DEQ) && (count != '0));
  assign append = (state == S_APPLY) && (mode_r == MODE_ENQ) && !found &&
                  (count != FULL_CNT);

  // A changed entry picks up its new data as it wraps to the last cell.
  assign wrap_data = edit ? data_r : cell_data[0];

  assign out_free  = !rsp.valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE);

  // Ring of cells, each taking its neighbor's entry on rotation.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    localparam int NXT = (i + 1) % DEPTH;
    cell_ctrl_t ctrl;

    assign ctrl.rotate = rotate;
    assign ctrl.load   = append && (count == IDX);

    kcf_cell #(
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .nbr_key  (cell_key[NXT]),
      .nbr_data ((i == DEPTH - 1) ? wrap_data : cell_data[NXT]),
      .new_key  (key_r),
      .new_data (data_r),
      .key      (cell_key[i]),
      .data     (cell_data[i])
    );
  end

  // Command sequencer, queue bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rear_r    <= '0;
      found     <= 1'b0;
      step      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // The result register fills from the report state and empties on handshake.
      if (state == S_REPORT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            mode_r   <= cmd.mode;
            key_r    <= cmd.key;
            data_r   <= cmd.data;
            found    <= 1'b0;
            step     <= '0;
            status_r <= ST_OK;
            rkey_r   <= '0;
            rdata_r  <= '0;
            if (cmd.mode == MODE_ENQ || cmd.mode == MODE_PEEK ||
                cmd.mode == MODE_CHANGE) begin
              state <= S_SCAN;
            end else begin
              state <= S_APPLY;
            end
          end
        end
        S_SCAN: begin
          if (match_now) begin
            found <= 1'b1;
            if (mode_r == MODE_PEEK) begin
              rdata_r <= cell_data[0];
            end
          end
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          case (mode_r)
            MODE_ENQ: begin
              if (found) begin
                status_r <= ST_DUP;
              end else if (count == FULL_CNT) begin
                status_r <= ST_FULL;
              end else begin
                count  <= count + 1'b1;
                rear_r <= key_r;
              end
            end
            MODE_DEQ: begin
              if (count == '0) begin
                status_r <= ST_EMPTY;
              end else begin
                rkey_r  <= cell_key[0];
                rdata_r <= cell_data[0];
                count   <= count - 1'b1;
              end
            end
            MODE_PEEK, MODE_CHANGE: begin
              if (!found) begin
                status_r <= ST_MISSING;
              end
            end
            MODE_CLEAR: begin
              count <= '0;
            end
            default: begin
              status_r <= ST_OK;
            end
          endcase
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            rsp.status      <= status_r;
            rsp.out_key     <= rkey_r;
            rsp.out_data    <= rdata_r;
            rsp.occupancy   <= count;
            rsp.queue_empty <= (count == '0);
            rsp.front_key   <= (count == '0) ? '0 : cell_key[0];
            rsp.rear_key    <= (count == '0) ? '0 : rear_r;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  // A successful dequeue removes exactly one entry.
  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && mode_r == MODE_DEQ && count != '0)
    |=> count == $past(count) - 1'b1)
    else $error("dequeue did not remove one entry");

  // The empty flag agrees with the reported occupancy.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.queue_empty == (rsp.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  // An empty queue reports zero front and rear keys.
  a_empty_keys: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.queue_empty) |-> (rsp.front_key == '0 && rsp.rear_key == '0))
    else $error("empty queue reports a key");

  // A scan ends after exactly one trip around the ring.
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && step == LAST_STEP) |=> state == S_APPLY)
    else $error("scan did not end after one rotation");

endmodule

`default_nettype wire
